// ----- sv/first_fit_block_allocator_assert.svh -----
// Assertion macros used by the first-fit block allocator controller.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FFBA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define FFBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

// ----- sv/ffba_pkg.sv -----
// Shared types and constants of the first-fit block allocator.
package ffba_pkg;

   localparam int LEN_W        = 16;
   localparam int HEADER_BYTES = 8;
   localparam logic [LEN_W-1:0] POOL_RESET = 16'd4096;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NO_FIT  = 2'd1;
   localparam logic [1:0] STATUS_UNKNOWN = 2'd2;
   localparam logic [1:0] STATUS_FULL    = 2'd3;

   typedef struct packed {
      logic capture_req;
      logic init_pool;
      logic scan_step;
      logic scan_wrap;
      logic alloc_scan;
      logic used_scan;
      logic free_scan;
      logic update;
      logic stats_scan;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic free_last;
      logic used_last;
      logic scan_last;
   } stat_type;

endpackage

// ----- sv/ffba_ctrl.sv -----
// Controller state machine of the first-fit block allocator.
`include "first_fit_block_allocator_assert.svh"

module ffba_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic               req_op,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic               csr_tvalid,
   output logic               csr_tready,
   input  ffba_pkg::stat_type stat,
   output ffba_pkg::cmd_type  cmd
);
   import ffba_pkg::*;

   localparam logic [2:0] S_IDLE       = 3'd0;
   localparam logic [2:0] S_ALLOC_SCAN = 3'd1;
   localparam logic [2:0] S_USED_SCAN  = 3'd2;
   localparam logic [2:0] S_FREE_SCAN  = 3'd3;
   localparam logic [2:0] S_UPDATE     = 3'd4;
   localparam logic [2:0] S_STATS      = 3'd5;
   localparam logic [2:0] S_DONE       = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.init_pool = csr_tvalid;
            if (req_tvalid) begin
               cmd.capture_req = 1'b1;
               state_in = (req_op == OP_FREE) ? S_USED_SCAN : S_ALLOC_SCAN;
            end
         end
         S_ALLOC_SCAN: begin
            cmd.alloc_scan = 1'b1;
            cmd.scan_step  = 1'b1;
            cmd.scan_wrap  = stat.scan_last;
            if (stat.scan_last) state_in = S_UPDATE;
         end
         S_USED_SCAN: begin
            cmd.used_scan = 1'b1;
            cmd.scan_step = 1'b1;
            cmd.scan_wrap = stat.used_last;
            if (stat.used_last) state_in = S_FREE_SCAN;
         end
         S_FREE_SCAN: begin
            cmd.free_scan = 1'b1;
            cmd.scan_step = 1'b1;
            cmd.scan_wrap = stat.free_last;
            if (stat.free_last) state_in = S_UPDATE;
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = S_STATS;
         end
         S_STATS: begin
            cmd.stats_scan = 1'b1;
            cmd.scan_step  = 1'b1;
            cmd.scan_wrap  = stat.free_last;
            if (stat.free_last) state_in = S_DONE;
         end
         S_DONE: begin
            // The output register is free once its pending transaction is taken.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `FFBA_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_tvalid && req_tready, state_ff != S_IDLE)
   `FFBA_ASSERT_NEXT(a_update_then_stats, clock, reset, state_ff == S_UPDATE, state_ff == S_STATS)
   `FFBA_ASSERT_NEXT(a_load_shows_result, clock, reset, cmd.load_rsp, rsp_tvalid)
   `FFBA_ASSERT_NEXT(a_pending_not_overwritten, clock, reset, (state_ff == S_DONE) && rsp_tvalid && !rsp_tready, state_ff == S_DONE)

endmodule

// ----- sv/ffba_datapath.sv -----
// Datapath of the first-fit block allocator: tables, scan counter and result registers.
module ffba_datapath #(
   parameter int MAX_FREE_BLOCKS = 16,
   parameter int MAX_USED_BLOCKS = 16,
   parameter int ADDR_BITS       = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_op,
   input  logic [ffba_pkg::LEN_W-1:0] req_size,
   input  logic [15:0]               req_addr,
   input  logic [ffba_pkg::LEN_W-1:0] csr_data,
   input  ffba_pkg::cmd_type         cmd,
   output ffba_pkg::stat_type        stat,
   output logic [55:0]               rsp_data
);
   import ffba_pkg::*;

   localparam int SCAN_N = (MAX_FREE_BLOCKS > MAX_USED_BLOCKS) ? MAX_FREE_BLOCKS
                                                                : MAX_USED_BLOCKS;
   localparam int CW = $clog2(SCAN_N);
   localparam int FW = $clog2(MAX_FREE_BLOCKS);
   localparam int UW = (MAX_USED_BLOCKS > 1) ? $clog2(MAX_USED_BLOCKS) : 1;
   localparam logic [CW-1:0] FREE_LAST = CW'(MAX_FREE_BLOCKS - 1);
   localparam logic [CW-1:0] USED_LAST = CW'(MAX_USED_BLOCKS - 1);
   localparam logic [CW-1:0] SCAN_LAST = CW'(SCAN_N - 1);

   logic [ADDR_BITS-1:0] free_start_ff [MAX_FREE_BLOCKS];
   logic [LEN_W-1:0]     free_len_ff   [MAX_FREE_BLOCKS];
   logic                 free_valid_ff [MAX_FREE_BLOCKS];
   logic [ADDR_BITS-1:0] used_addr_ff  [MAX_USED_BLOCKS];
   logic [LEN_W-1:0]     used_len_ff   [MAX_USED_BLOCKS];
   logic                 used_valid_ff [MAX_USED_BLOCKS];

   logic                 op_ff;
   logic [LEN_W-1:0]     size_ff;
   logic [15:0]          addr_ff;
   logic [CW-1:0]        cnt_ff;

   logic                 pick_found_ff, slot_found_ff, u_found_ff;
   logic [FW-1:0]        pick_idx_ff;
   logic [ADDR_BITS-1:0] pick_start_ff;
   logic [LEN_W-1:0]     pick_len_ff;
   logic [UW-1:0]        slot_idx_ff, u_idx_ff;
   logic [ADDR_BITS-1:0] s_ff;
   logic [LEN_W-1:0]     l_ff;
   logic                 prev_found_ff, next_found_ff, spare_found_ff;
   logic [FW-1:0]        prev_idx_ff, next_idx_ff, spare_idx_ff;
   logic [LEN_W-1:0]     prev_len_ff, next_len_ff;

   logic [1:0]           res_status_ff;
   logic [15:0]          res_granted_ff;
   logic [LEN_W-1:0]     sum_ff, max_ff;
   logic [55:0]          rsp_data_ff;

   logic [FW-1:0]        fi;
   logic [UW-1:0]        ui;
   logic                 f_in, u_in;
   logic [ADDR_BITS-1:0] rd_start, rd_uaddr;
   logic [LEN_W-1:0]     rd_len, rd_ulen;
   logic                 rd_valid, rd_uvalid;
   logic [LEN_W:0]       need;
   logic [LEN_W-1:0]     rem;
   logic                 split;
   logic [31:0]          split_start32, grant32, uplus32, end32, snext32;
   logic                 merge_both, free_ok;
   logic [1:0]           status;
   logic [LEN_W-1:0]     prev_sum, next_sum, used_take;

   assign fi = cnt_ff[FW-1:0];
   assign ui = cnt_ff[UW-1:0];
   assign f_in = ({1'b0, cnt_ff} < (CW+1)'(MAX_FREE_BLOCKS));
   assign u_in = ({1'b0, cnt_ff} < (CW+1)'(MAX_USED_BLOCKS));

   assign rd_start  = free_start_ff[fi];
   assign rd_len    = free_len_ff[fi];
   assign rd_valid  = free_valid_ff[fi] && f_in;
   assign rd_uaddr  = used_addr_ff[ui];
   assign rd_ulen   = used_len_ff[ui];
   assign rd_uvalid = used_valid_ff[ui];

   assign stat.free_last = (cnt_ff == FREE_LAST);
   assign stat.used_last = (cnt_ff == USED_LAST);
   assign stat.scan_last = (cnt_ff == SCAN_LAST);

   assign need          = {1'b0, size_ff} + (LEN_W+1)'(HEADER_BYTES);
   assign rem           = pick_len_ff - need[LEN_W-1:0];
   assign split         = (rem > LEN_W'(HEADER_BYTES));
   assign split_start32 = 32'(pick_start_ff) + 32'(need);
   assign grant32       = 32'(pick_start_ff) + 32'(HEADER_BYTES);
   assign uplus32       = 32'(rd_uaddr) + 32'(HEADER_BYTES);
   assign end32         = 32'(rd_start) + 32'(rd_len);
   assign snext32       = 32'(s_ff) + 32'(l_ff);

   assign merge_both = next_found_ff && (next_idx_ff != prev_idx_ff);
   assign free_ok    = prev_found_ff || next_found_ff || spare_found_ff;
   assign prev_sum   = prev_len_ff + l_ff + (merge_both ? next_len_ff : '0);
   assign next_sum   = next_len_ff + l_ff;
   assign used_take  = split ? need[LEN_W-1:0] : pick_len_ff;

   always_comb begin
      if (op_ff == OP_ALLOC) begin
         priority if (!pick_found_ff) status = STATUS_NO_FIT;
         else if (!slot_found_ff)     status = STATUS_FULL;
         else                         status = STATUS_OK;
      end else begin
         priority if (!u_found_ff) status = STATUS_UNKNOWN;
         else if (!free_ok)        status = STATUS_FULL;
         else                      status = STATUS_OK;
      end
   end

   // Table storage: pool init, allocate and free updates.
   always_ff @(posedge clock) begin
      if (reset || cmd.init_pool) begin
         for (int i = 0; i < MAX_FREE_BLOCKS; i++) free_valid_ff[i] <= 1'b0;
         for (int i = 0; i < MAX_USED_BLOCKS; i++) used_valid_ff[i] <= 1'b0;
         free_start_ff[0] <= '0;
         if (reset) begin
            free_len_ff[0]   <= POOL_RESET;
            free_valid_ff[0] <= 1'b1;
         end else begin
            free_len_ff[0]   <= csr_data;
            free_valid_ff[0] <= (csr_data != '0);
         end
      end else if (cmd.update && status == STATUS_OK) begin
         if (op_ff == OP_ALLOC) begin
            used_addr_ff[slot_idx_ff]  <= pick_start_ff;
            used_len_ff[slot_idx_ff]   <= used_take;
            used_valid_ff[slot_idx_ff] <= 1'b1;
            if (split) begin
               free_start_ff[pick_idx_ff] <= split_start32[ADDR_BITS-1:0];
               free_len_ff[pick_idx_ff]   <= rem;
            end else begin
               free_valid_ff[pick_idx_ff] <= 1'b0;
            end
         end else begin
            used_valid_ff[u_idx_ff] <= 1'b0;
            priority if (prev_found_ff) begin
               free_len_ff[prev_idx_ff] <= prev_sum;
               if (merge_both) free_valid_ff[next_idx_ff] <= 1'b0;
            end else if (next_found_ff) begin
               free_start_ff[next_idx_ff] <= s_ff;
               free_len_ff[next_idx_ff]   <= next_sum;
            end else begin
               free_start_ff[spare_idx_ff] <= s_ff;
               free_len_ff[spare_idx_ff]   <= l_ff;
               free_valid_ff[spare_idx_ff] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.scan_step) begin
         cnt_ff <= cmd.scan_wrap ? '0 : cnt_ff + 1'b1;
      end
   end

   // Scan captures and request registers.
   always_ff @(posedge clock) begin
      if (cmd.capture_req) begin
         op_ff          <= req_op;
         size_ff        <= req_size;
         addr_ff        <= req_addr;
         pick_found_ff  <= 1'b0;
         slot_found_ff  <= 1'b0;
         u_found_ff     <= 1'b0;
         prev_found_ff  <= 1'b0;
         next_found_ff  <= 1'b0;
         spare_found_ff <= 1'b0;
      end
      if (cmd.alloc_scan) begin
         if (rd_valid && ({1'b0, rd_len} >= need) &&
             (!pick_found_ff || rd_start < pick_start_ff)) begin
            pick_found_ff <= 1'b1;
            pick_idx_ff   <= fi;
            pick_start_ff <= rd_start;
            pick_len_ff   <= rd_len;
         end
         if (u_in && !slot_found_ff && !rd_uvalid) begin
            slot_found_ff <= 1'b1;
            slot_idx_ff   <= ui;
         end
      end
      if (cmd.used_scan && !u_found_ff && rd_uvalid &&
          (32'(uplus32[ADDR_BITS-1:0]) == 32'(addr_ff))) begin
         u_found_ff <= 1'b1;
         u_idx_ff   <= ui;
         s_ff       <= rd_uaddr;
         l_ff       <= rd_ulen;
      end
      if (cmd.free_scan) begin
         if (!rd_valid) begin
            if (!spare_found_ff) begin
               spare_found_ff <= 1'b1;
               spare_idx_ff   <= fi;
            end
         end else begin
            if (!prev_found_ff && end32[ADDR_BITS-1:0] == s_ff) begin
               prev_found_ff <= 1'b1;
               prev_idx_ff   <= fi;
               prev_len_ff   <= rd_len;
            end
            if (!next_found_ff && rd_start == snext32[ADDR_BITS-1:0]) begin
               next_found_ff <= 1'b1;
               next_idx_ff   <= fi;
               next_len_ff   <= rd_len;
            end
         end
      end
   end

   // Result and free-space statistics.
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         res_status_ff  <= status;
         res_granted_ff <= (op_ff == OP_ALLOC && status == STATUS_OK)
                           ? 16'(grant32[ADDR_BITS-1:0]) : '0;
         sum_ff         <= '0;
         max_ff         <= '0;
      end else if (cmd.stats_scan && rd_valid) begin
         sum_ff <= sum_ff + rd_len;
         if (rd_len > max_ff) max_ff <= rd_len;
      end
      if (cmd.load_rsp) begin
         rsp_data_ff <= {6'd0, max_ff, sum_ff, res_granted_ff, res_status_ff};
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

// ----- sv/first_fit_block_allocator.sv -----
// Top level of the first-fit block allocator with coalescing.
// Allocate: one scan over max(MAX_FREE_BLOCKS, MAX_USED_BLOCKS) entries, update, stats scan over the free table.
// Free: scan of the used table, scan of the free table, update, stats scan over the free table.
// One request at a time: a new one is taken only after the previous result is loaded
// into the output register, which waits while a finished result is still waiting.
// Synchronous reset leaves one free block of 4096 bytes at offset 0 and no used blocks.
module first_fit_block_allocator #(
   parameter int MAX_FREE_BLOCKS = 16,
   parameter int MAX_USED_BLOCKS = 16,
   parameter int ADDR_BITS       = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // request_size [15:0], block_address [31:16]
   input  logic [0:0]  req_tuser,  // operation [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // status [1:0], granted_address [17:2],
                                   // free_bytes [33:18], largest_free [49:34], zero pad
   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic [15:0] csr_tdata   // pool_size [15:0]
);
   import ffba_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   ffba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser[0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ffba_datapath #(
      .MAX_FREE_BLOCKS (MAX_FREE_BLOCKS),
      .MAX_USED_BLOCKS (MAX_USED_BLOCKS),
      .ADDR_BITS       (ADDR_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_op   (req_tuser[0]),
      .req_size (req_tdata[15:0]),
      .req_addr (req_tdata[31:16]),
      .csr_data (csr_tdata),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_tdata)
   );

endmodule
